// ----- hw/rtl/positional_insert_erase_list_unit_assert.svh -----
// Assertion macros for the list unit checker.
`ifndef POSITIONAL_INSERT_ERASE_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_INSERT_ERASE_LIST_UNIT_ASSERT_SVH

// Clocked assertion, off during reset.
`define PIEL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked only while a result word is offered.
`define PIEL_ASSERT_OUT(lbl, prop, msg) \
	`PIEL_ASSERT(lbl, m_tvalid |-> (prop), msg)

`endif

// ----- hw/rtl/piel_pkg.sv -----
package piel_pkg;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_ERASE  = 2'd1,
		KIND_READ   = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_ERA  = 2'd2
	} cell_op_t;

	localparam int unsigned FIELD_W   = 7;
	localparam int unsigned PORT_DW   = 32;
	localparam int unsigned TDATA_W   = 40;
	localparam logic [FIELD_W-1:0] CAP_RESET = 7'd64;

endpackage

// ----- hw/rtl/piel_cell.sv -----
module piel_cell
	import piel_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned XW = 7,
	parameter int unsigned IDX = 0
) (
	input  logic                  clk,
	input  cell_op_t              op,
	input  logic [XW-1:0]         pos,
	input  logic [DATA_WIDTH-1:0] wval,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] q,
	output logic [DATA_WIDTH-1:0] hit
);

	localparam logic [XW-1:0] IDX_X = XW'(IDX);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_INS: begin
				if (IDX_X == pos) begin
					data_q <= wval;
				end else if (IDX_X > pos) begin
					data_q <= left;
				end
			end
			CELL_ERA: begin
				if (IDX_X >= pos) begin
					data_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign q   = data_q;
	assign hit = (IDX_X == pos) ? data_q : '0;

endmodule

// ----- hw/rtl/positional_insert_erase_list_unit.sv -----
// Ordered list of up to min(capacity, MAX_ENTRIES) entries held in a row of cells.
// Each input word is one operation (tuser kind: insert, erase, read, or no-op);
// insert and erase shift every cell above the position by one place in the same
// cycle, so one word is taken per clock while no result is stalled; its result word
// appears in the output register on the next clock. The entry count register closes
// the only loop, one update per cycle. Rejected operations (full, bad position)
// change nothing and report their status. Write capacity only while idle; entries
// start undefined and need no clearing: only positions below the count are read.
module positional_insert_erase_list_unit
	import piel_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [6:0]         cfg_wdata,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [39:0]        s_tdata,  // position[6:0], value[38:7], zero pad[39]
	input  logic [1:0]         s_tuser,  // kind[1:0]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [39:0]        m_tdata,  // read_value[31:0], count[38:32], is_empty[39]
	output logic [1:0]         m_tuser   // status[1:0]
);

	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned XW = (CW > FIELD_W) ? CW : FIELD_W;
	localparam logic [XW-1:0] MAX_X = XW'(MAX_ENTRIES);

	logic [FIELD_W-1:0]     capacity_q;
	logic [CW-1:0]          count_q;
	logic                   m_valid_q;
	logic [1:0]             status_q;
	logic [PORT_DW-1:0]     rdata_q;
	logic [FIELD_W-1:0]     ocount_q;
	logic                   empty_q;

	logic                   accept;
	kind_t                  kind;
	logic [XW-1:0]          pos_x;
	logic [XW-1:0]          cnt_x;
	logic [XW-1:0]          cap_x;
	logic [DATA_WIDTH+31:0] val_x;
	logic [DATA_WIDTH-1:0]  wval;
	logic                   full;
	logic                   ins_ok;
	logic                   pos_ok;
	cell_op_t               cell_op;
	status_t                status;
	logic [CW-1:0]          count_nx;
	logic [XW-1:0]          count_nx_x;
	logic [DATA_WIDTH-1:0]  rd_or;
	logic [DATA_WIDTH+31:0] rd_x;

	logic [DATA_WIDTH-1:0]  ent [MAX_ENTRIES];
	logic [DATA_WIDTH-1:0]  hit [MAX_ENTRIES];

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign kind     = kind_t'(s_tuser);
	assign pos_x    = XW'(s_tdata[FIELD_W-1:0]);
	assign cnt_x    = XW'(count_q);
	assign cap_x    = XW'(capacity_q);
	assign val_x    = {{DATA_WIDTH{1'b0}}, s_tdata[FIELD_W+PORT_DW-1:FIELD_W]};
	assign wval     = val_x[DATA_WIDTH-1:0];

	assign full   = (cnt_x >= cap_x) || (cnt_x >= MAX_X);
	assign ins_ok = pos_x <= cnt_x;
	assign pos_ok = pos_x < cnt_x;

	always_comb begin
		status   = ST_DONE;
		cell_op  = CELL_HOLD;
		count_nx = count_q;
		case (kind)
			KIND_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else if (!ins_ok) begin
					status = ST_RANGE;
				end else begin
					cell_op  = CELL_INS;
					count_nx = count_q + 1'b1;
				end
			end
			KIND_ERASE: begin
				if (!pos_ok) begin
					status = ST_RANGE;
				end else begin
					cell_op  = CELL_ERA;
					count_nx = count_q - 1'b1;
				end
			end
			KIND_READ: begin
				if (!pos_ok) begin
					status = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
		if (!accept) begin
			cell_op = CELL_HOLD;
		end
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left;
		logic [DATA_WIDTH-1:0] right;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_left
			assign left = ent[i-1];
		end
		if (i == MAX_ENTRIES - 1) begin : g_last
			assign right = '0;
		end else begin : g_right
			assign right = ent[i+1];
		end
		piel_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.XW(XW),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.op(cell_op),
			.pos(pos_x),
			.wval(wval),
			.left(left),
			.right(right),
			.q(ent[i]),
			.hit(hit[i])
		);
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			rd_or = rd_or | hit[i];
		end
	end

	assign rd_x       = {32'b0, rd_or};
	assign count_nx_x = XW'(count_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			count_q    <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				capacity_q <= cfg_wdata;
			end
			if (accept) begin
				count_q   <= count_nx;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status;
			rdata_q  <= (kind == KIND_READ && status == ST_DONE) ? rd_x[PORT_DW-1:0] : '0;
			ocount_q <= count_nx_x[FIELD_W-1:0];
			empty_q  <= (count_nx == '0);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {empty_q, ocount_q, rdata_q};

endmodule

// ----- hw/rtl/piel_checker.sv -----
`include "positional_insert_erase_list_unit_assert.svh"

module piel_checker
	import piel_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wen,
	input logic [6:0]  cfg_wdata,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [39:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	`PIEL_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled word changed")
	`PIEL_ASSERT(a_result, s_tvalid && s_tready |=> m_tvalid, "accepted word gave no result")
	`PIEL_ASSERT_OUT(a_empty, m_tdata[39] == (m_tdata[38:32] == 7'd0), "empty flag mismatch")
	`PIEL_ASSERT_OUT(a_rdzero, m_tuser == ST_DONE || m_tdata[31:0] == 32'd0, "rejected op read data")

endmodule

bind positional_insert_erase_list_unit piel_checker u_piel_checker (.*);

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import piel_pkg::*;

	localparam int LIST_DEPTH = 64;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		status_t     status;
		logic [31:0] read_value;
		logic [6:0]  count;
		logic        is_empty;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [6:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // position[6:0], value[38:7], zero pad[39]
	logic [1:0]  s_tuser = '0;   // kind[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // read_value[31:0], count[38:32], is_empty[39]
	logic [1:0]  m_tuser;        // status[1:0]

	logic [31:0]  list_mem [LIST_DEPTH];
	int           list_len = 0;
	int           cap_setting = 64;
	list_result_t pending_results [$];
	int           err_count = 0;
	int           idle_cycles = 0;
	int           rx_wait = 0;
	bit           tx_quiet = 1'b0;
	bit           rx_quiet = 1'b0;

	positional_insert_erase_list_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_gap(bit quiet);
		if (quiet)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	function automatic list_result_t predict_list_op(kind_t op, logic [6:0] pos,
			logic [31:0] val);
		list_result_t r;
		int lim;
		int p;
		int i;
		r.status = ST_DONE;
		r.read_value = '0;
		lim = (cap_setting > LIST_DEPTH) ? LIST_DEPTH : cap_setting;
		p = pos;
		case (op)
			KIND_INSERT: begin
				if (list_len >= lim)
					r.status = ST_FULL;
				else if (p > list_len)
					r.status = ST_RANGE;
				else begin
					for (i = list_len; i > p; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[p] = val;
					list_len++;
				end
			end
			KIND_ERASE: begin
				if (p >= list_len)
					r.status = ST_RANGE;
				else begin
					for (i = p; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
				end
			end
			KIND_READ: begin
				if (p >= list_len)
					r.status = ST_RANGE;
				else
					r.read_value = list_mem[p];
			end
			default: ;
		endcase
		r.count = 7'(list_len);
		r.is_empty = (list_len == 0);
		return r;
	endfunction

	task automatic note_failure(string msg);
		if (err_count < 10)
			$display("mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic check_result_word();
		list_result_t want;
		if (pending_results.size() == 0) begin
			note_failure($sformatf("unexpected word, status %0d data %h", m_tuser, m_tdata));
			return;
		end
		want = pending_results.pop_front();
		if (m_tuser !== want.status)
			note_failure($sformatf("status expected %0d, got %0d", want.status, m_tuser));
		if (m_tdata[31:0] !== want.read_value)
			note_failure($sformatf("read_value expected %h, got %h",
				want.read_value, m_tdata[31:0]));
		if (m_tdata[38:32] !== want.count)
			note_failure($sformatf("count expected %0d, got %0d", want.count, m_tdata[38:32]));
		if (m_tdata[39] !== want.is_empty)
			note_failure($sformatf("is_empty expected %0d, got %0d",
				want.is_empty, m_tdata[39]));
	endtask

	always @(posedge clk or negedge arst_n) begin : rx_side
		int w;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait <= 0;
		end else if (m_tvalid && m_tready) begin
			check_result_word();
			w = draw_gap(rx_quiet);
			m_tready <= (w == 0);
			rx_wait <= w;
		end else if (rx_wait > 1) begin
			rx_wait <= rx_wait - 1;
		end else begin
			rx_wait <= 0;
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_word(kind_t op, logic [6:0] pos, logic [31:0] val);
		int gap;
		gap = draw_gap(tx_quiet);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, val, pos};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_list_op(op, pos, val));
	endtask

	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_capacity(int cap);
		wait_results_done();
		cfg_wen <= 1'b1;
		cfg_wdata <= 7'(cap);
		@(posedge clk);
		cfg_wen <= 1'b0;
		cap_setting = cap & 7'h7f;
	endtask

	task automatic send_random_word(int ins_pct, int era_pct);
		int roll;
		kind_t op;
		logic [6:0] pos;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			op = KIND_INSERT;
		else if (roll < ins_pct + era_pct)
			op = KIND_ERASE;
		else if (roll < 96)
			op = KIND_READ;
		else
			op = KIND_NOP;
		if ($urandom_range(0, 99) < 12)
			pos = 7'($urandom_range(0, 127));
		else if (op == KIND_INSERT)
			pos = 7'($urandom_range(0, list_len));
		else if (list_len != 0)
			pos = 7'($urandom_range(0, list_len - 1));
		else
			pos = '0;
		send_word(op, pos, $urandom);
	endtask

	task automatic run_phase(int cap, int n, int ins_pct, int era_pct, bit quiet);
		set_capacity(cap);
		tx_quiet = quiet;
		rx_quiet = quiet;
		repeat (n) send_random_word(ins_pct, era_pct);
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	task automatic test_basic_ops();
		send_word(KIND_READ, 7'd0, 32'h0);
		send_word(KIND_ERASE, 7'd0, 32'h0);
		send_word(KIND_INSERT, 7'd1, 32'h1234_5678);
		send_word(KIND_INSERT, 7'd0, 32'h0000_0000);
		send_word(KIND_INSERT, 7'd1, 32'hffff_ffff);
		send_word(KIND_INSERT, 7'd1, 32'ha5a5_5a5a);
		send_word(KIND_INSERT, 7'd0, 32'h0000_0001);
		send_word(KIND_READ, 7'd0, 32'hffff_ffff);
		send_word(KIND_READ, 7'd1, 32'h0);
		send_word(KIND_READ, 7'd2, 32'h0);
		send_word(KIND_READ, 7'd3, 32'h0);
		send_word(KIND_READ, 7'd127, 32'h0);
		send_word(KIND_ERASE, 7'd127, 32'h0);
		send_word(KIND_INSERT, 7'd127, 32'hdead_beef);
		send_word(KIND_NOP, 7'd127, 32'hffff_ffff);
		send_word(KIND_ERASE, 7'd1, 32'h0);
		send_word(KIND_ERASE, 7'd2, 32'h0);
		send_word(KIND_ERASE, 7'd0, 32'h0);
		send_word(KIND_READ, 7'd0, 32'h0);
	endtask

	task automatic test_capacity_limits();
		set_capacity(0);
		send_word(KIND_INSERT, 7'd0, 32'h5555_aaaa);
		send_word(KIND_INSERT, 7'd127, 32'h5555_aaaa);
		set_capacity(2);
		send_word(KIND_INSERT, 7'd1, 32'h0f0f_0f0f);
		send_word(KIND_INSERT, 7'd0, 32'hf0f0_f0f0);
		send_word(KIND_INSERT, 7'd127, 32'hf0f0_f0f0);
		set_capacity(1);
		send_word(KIND_INSERT, 7'd0, 32'h1111_1111);
		send_word(KIND_READ, 7'd1, 32'h0);
		send_word(KIND_ERASE, 7'd0, 32'h0);
		send_word(KIND_INSERT, 7'd0, 32'h2222_2222);
		send_word(KIND_ERASE, 7'd0, 32'h0);
		send_word(KIND_READ, 7'd0, 32'h0);
	endtask

	task automatic test_random_phases();
		run_phase(64, 150, 65, 20, 1'b0);
		run_phase(127, 120, 60, 20, 1'b1);
		run_phase(5, 100, 30, 45, 1'b0);
		run_phase(3, 60, 45, 35, 1'b0);
		run_phase(0, 40, 40, 30, 1'b0);
		run_phase(33, 130, 55, 30, 1'b0);
		run_phase(100, 120, 45, 40, 1'b0);
		run_phase(1, 60, 45, 35, 1'b1);
		run_phase(64, 100, 40, 40, 1'b0);
	endtask

	task automatic test_drain_pause();
		repeat (30) send_random_word(50, 30);
		wait_results_done();
		repeat (30) send_random_word(40, 40);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_capacity_limits();
		test_random_phases();
		test_drain_pause();
		wait_results_done();
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
